### rtl/lru_slot_cache_defines.svh
// assertion macros shared by the rtl
`ifndef LRU_SLOT_CACHE_DEFINES_SVH
`define LRU_SLOT_CACHE_DEFINES_SVH

`ifndef SYNTHESIS
// checked property, off while reset is high
`define LSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked property, also during reset
`define LSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LSC_ASSERT(lbl, prop, msg)
`define LSC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/lsc_pkg.sv
`default_nettype none

package lsc_pkg;

  localparam int ENTRIES  = 2048;
  localparam int TAG_BITS = 16;
  localparam int CODE_W   = 16;
  localparam int SLOT_W   = 11;
  localparam int CAP_W    = 12;
  localparam int ADDR_W   = $clog2(ENTRIES);
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  // width wide enough to compare capacity against counts
  localparam int CW       = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(2048);

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [ADDR_W-1:0]   slot;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

### rtl/lsc_entry_mem.sv
`default_nettype none

module lsc_entry_mem
  import lsc_pkg::*;
(
  input  wire logic     clk,
  input  var  mem_req_t req,
  output entry_t        rdata
);

  entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

`default_nettype wire

### rtl/lsc_scan.sv
`default_nettype none

`include "lru_slot_cache_defines.svh"

module lsc_scan
  import lsc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [CAP_W-1:0]  capacity,
  input  wire logic              start,
  input  wire logic [CODE_W-1:0] code,
  output logic                   ready,
  output logic                   res_valid,
  input  wire logic              res_take,
  output logic [SLOT_W-1:0]      res_slot,
  output logic                   res_fill,
  output mem_req_t               req,
  input  var  entry_t            rdata
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_CMP   = 5'b00100,
    S_TAIL  = 5'b01000,
    S_FRONT = 5'b10000
  } state_t;

  state_t               state, state_next;
  logic [TAG_BITS-1:0]  tag;
  logic [CNT_W-1:0]     live;
  logic [CNT_W-1:0]     idx;
  logic [CNT_W-1:0]     idx_inc;
  logic [CNT_W-1:0]     fill_count;
  logic                 room;
  logic                 need_fill;
  entry_t               carry;
  entry_t               front;

  logic [CW-1:0]        cap_eff;
  logic [CW-1:0]        fill_ext;
  logic [CW-1:0]        live_calc;
  logic [TAG_BITS-1:0]  tag_in;
  logic                 hit;
  logic                 last;

  assign tag_in  = TAG_BITS'(code);
  assign idx_inc = idx + CNT_W'(1);
  assign hit     = (rdata.tag == tag);
  assign last    = (idx_inc == live);

  always_comb begin
    cap_eff = CW'(capacity);
    if (capacity == '0) begin
      cap_eff = CW'(1);
    end else if (CW'(capacity) > CW'(ENTRIES)) begin
      cap_eff = CW'(ENTRIES);
    end
    fill_ext  = CW'(fill_count);
    live_calc = (fill_ext < cap_eff) ? fill_ext : cap_eff;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = (live_calc == '0) ? S_FRONT : S_READ;
        end
      end
      S_READ: begin
        state_next = S_CMP;
      end
      S_CMP: begin
        if (hit) begin
          state_next = S_FRONT;
        end else if (last) begin
          state_next = room ? S_TAIL : S_FRONT;
        end else begin
          state_next = S_READ;
        end
      end
      S_TAIL: begin
        state_next = S_FRONT;
      end
      S_FRONT: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // memory port: entry idx takes the previous entry as the scan moves on
  always_comb begin
    req.we    = 1'b0;
    req.waddr = idx[ADDR_W-1:0];
    req.wdata = carry;
    req.raddr = idx[ADDR_W-1:0];
    unique case (state)
      S_CMP: begin
        req.we = (idx != '0);
      end
      S_TAIL: begin
        req.we    = 1'b1;
        req.waddr = idx_inc[ADDR_W-1:0];
      end
      S_FRONT: begin
        req.we    = 1'b1;
        req.waddr = '0;
        req.wdata = front;
      end
      default: req.we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && start && live_calc == '0) begin
        fill_count <= fill_count + CNT_W'(1);
      end
      if (state == S_CMP && !hit && last && room) begin
        fill_count <= fill_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (start) begin
          tag       <= tag_in;
          live      <= CNT_W'(live_calc);
          room      <= (fill_ext < cap_eff);
          idx       <= '0;
          need_fill <= 1'b1;
          front     <= '{tag: tag_in, slot: fill_count[ADDR_W-1:0]};
        end
      end
      S_CMP: begin
        if (hit) begin
          front     <= rdata;
          need_fill <= 1'b0;
        end else begin
          carry <= rdata;
          if (last) begin
            // miss: new slot when there is room, else reuse the victim's slot
            front.tag  <= tag;
            front.slot <= room ? fill_count[ADDR_W-1:0] : rdata.slot;
          end else begin
            idx <= idx_inc;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign ready     = (state == S_IDLE);
  assign res_valid = (state == S_FRONT);
  assign res_slot  = SLOT_W'(front.slot);
  assign res_fill  = need_fill;

  `LSC_ASSERT(a_fill_bound, fill_count <= CNT_W'(ENTRIES), "fill count beyond entry count")
  `LSC_ASSERT(a_idx_live, (state == S_CMP) |-> (idx < live), "scan index past live entries")
  `LSC_ASSERT(a_hit_keeps_fill, (state == S_CMP && hit) |=> $stable(fill_count),
              "hit changed fill count")
  `LSC_ASSERT(a_start_busy, (state == S_IDLE && start) |=> (state != S_IDLE),
              "accepted word left block idle")

endmodule

`default_nettype wire

### rtl/lru_slot_cache.sv
// channel   direction  handshake            payload
// input     in         in_valid / in_stall  char_code
// output    out        out_valid/out_stall  slot, need_fill
// config    in         capacity_we          capacity_wdata
//
// one word at a time; a word is searched from entry 0 up to a hit or the last live entry,
// with one read and one compare per entry on the entry memory
// the move-to-front shift rides along with the search, one write per entry read
// rst is synchronous; it empties the cache and sets capacity to 2048
// a new word is taken while a result waits in the output register
// in_stall is high from acceptance until the result is handed to the output register
`default_nettype none

module lru_slot_cache
  import lsc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [CODE_W-1:0] char_code,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [SLOT_W-1:0]      slot,
  output logic                   need_fill,
  input  wire logic              capacity_we,
  input  wire logic [CAP_W-1:0]  capacity_wdata
);

  logic [CAP_W-1:0]  capacity;
  logic              ready;
  logic              start;
  logic              res_valid;
  logic              res_take;
  logic [SLOT_W-1:0] res_slot;
  logic              res_fill;
  mem_req_t          req;
  entry_t            rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (capacity_we) begin
      capacity <= capacity_wdata;
    end
  end

  assign in_stall = !ready;
  assign start    = in_valid && ready;
  assign res_take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      slot      <= res_slot;
      need_fill <= res_fill;
    end
  end

  lsc_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .capacity  (capacity),
    .start     (start),
    .code      (char_code),
    .ready     (ready),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res_slot  (res_slot),
    .res_fill  (res_fill),
    .req       (req),
    .rdata     (rdata)
  );

  lsc_entry_mem u_mem (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench
  import lsc_pkg::*;
();

  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_PAUSE  = 16;
  localparam int NUM_ROWS    = 27;
  localparam int NUM_PHASES  = 7;
  localparam int PHASE_WORDS = 17;

  typedef enum logic {ROW_LOOKUP, ROW_CAPACITY} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [15:0]       value;
    bit                known;
    logic [SLOT_W-1:0] slot;
    logic              need_fill;
  } stim_row_t;

  typedef struct {
    logic [SLOT_W-1:0] slot;
    logic              need_fill;
  } slot_answer_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [CODE_W-1:0] char_code;
  logic              out_valid;
  logic              out_stall;
  logic [SLOT_W-1:0] slot;
  logic              need_fill;
  logic              capacity_we;
  logic [CAP_W-1:0]  capacity_wdata;

  // recency list mirror, most recent first
  logic [CODE_W-1:0] tag_list [ENTRIES];
  logic [SLOT_W-1:0] slot_list [ENTRIES];
  logic [CAP_W-1:0]  fill_cnt;
  logic [CAP_W-1:0]  cap_reg;

  slot_answer_t      slot_answers [$];
  stim_row_t         rows [NUM_ROWS];
  logic [CODE_W-1:0] code_pool [24];
  int                pool_n;
  int                phase_caps [NUM_PHASES] = '{3, 2048, 1, 0, 0, 4095, 6};
  int                bad_words;
  int                cycle_count;
  int                burst_left;
  bit                calm_send;
  bit                calm_recv;
  int                stall_left;
  int                free_left;

  lru_slot_cache u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .char_code      (char_code),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .slot           (slot),
    .need_fill      (need_fill),
    .capacity_we    (capacity_we),
    .capacity_wdata (capacity_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // search, then move to front; a miss fills a new slot or recycles the last live one
  function automatic void lru_lookup(input logic [CODE_W-1:0] code,
                                     output logic [SLOT_W-1:0] got_slot,
                                     output logic miss);
    int unsigned lim, live, pos, k;
    logic [CODE_W-1:0] t;
    logic [SLOT_W-1:0] s;
    lim = cap_reg;
    if (lim == 0) lim = 1;
    if (lim > ENTRIES) lim = ENTRIES;
    live = (fill_cnt < lim) ? fill_cnt : lim;
    pos = live;
    for (k = 0; k < live; k++) begin
      if (tag_list[k] == code) begin
        pos = k;
        break;
      end
    end
    miss = (pos == live);
    if (miss && fill_cnt < lim) begin
      pos = fill_cnt;
      tag_list[pos] = code;
      slot_list[pos] = SLOT_W'(pos);
      fill_cnt = fill_cnt + 1'b1;
    end else if (miss) begin
      pos = lim - 1;
      tag_list[pos] = code;
    end
    t = tag_list[pos];
    s = slot_list[pos];
    for (k = pos; k > 0; k--) begin
      tag_list[k] = tag_list[k-1];
      slot_list[k] = slot_list[k-1];
    end
    tag_list[0] = t;
    slot_list[0] = s;
    got_slot = s;
  endfunction

  task automatic lookup_code(input logic [CODE_W-1:0] code, input bit known,
                             input logic [SLOT_W-1:0] k_slot, input logic k_fill);
    slot_answer_t ans;
    @(negedge clk);
    in_valid <= 1'b1;
    char_code <= code;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lru_lookup(code, ans.slot, ans.need_fill);
    if (known) begin
      ans.slot = k_slot;
      ans.need_fill = k_fill;
    end
    slot_answers.push_back(ans);
  endtask

  // bursts of words separated by gaps of random length
  task automatic pace_sender();
    int gap;
    if (calm_send) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (gap - 1) @(negedge clk);
    burst_left = $urandom_range(0, 10);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (slot_answers.size() != 0) @(posedge clk);
    repeat (IDLE_PAUSE) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    wait_idle();
    @(negedge clk);
    capacity_we <= 1'b1;
    capacity_wdata <= value;
    @(posedge clk);
    cap_reg = value;
    @(negedge clk);
    capacity_we <= 1'b0;
  endtask

  function automatic logic [CODE_W-1:0] pick_code();
    if ($urandom_range(0, 4) == 0)
      return CODE_W'($urandom);
    return code_pool[$urandom_range(0, pool_n - 1)];
  endfunction

  // receiver stall pattern: runs of stall between free runs
  always @(negedge clk) begin
    if (calm_recv) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (free_left > 0) begin
      out_stall <= 1'b0;
      free_left--;
    end else begin
      out_stall <= 1'b0;
      stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : $urandom_range(0, 2);
      free_left = $urandom_range(0, 20);
    end
  end

  always @(posedge clk) begin : check_words
    slot_answer_t want;
    if (!rst && out_valid && !out_stall) begin
      if (slot_answers.size() == 0) begin
        bad_words++;
        if (bad_words <= 10)
          $display("unexpected word: slot %0d need_fill %0b", slot, need_fill);
      end else begin
        want = slot_answers.pop_front();
        if (slot !== want.slot || need_fill !== want.need_fill) begin
          bad_words++;
          if (bad_words <= 10)
            $display("word mismatch: expected slot %0d need_fill %0b, got slot %0d need_fill %0b",
                     want.slot, want.need_fill, slot, need_fill);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    char_code = '0;
    out_stall = 1'b0;
    capacity_we = 1'b0;
    capacity_wdata = '0;
    fill_cnt = '0;
    cap_reg = CAP_RESET;
    bad_words = 0;
    cycle_count = 0;
    burst_left = 0;
    calm_send = 1'b0;
    calm_recv = 1'b0;
    stall_left = 0;
    free_left = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      tag_list[i] = '0;
      slot_list[i] = '0;
    end

    rows = '{
      '{ROW_LOOKUP,   16'h0000, 1'b1, 11'd0, 1'b1},
      '{ROW_LOOKUP,   16'hFFFF, 1'b1, 11'd1, 1'b1},
      '{ROW_LOOKUP,   16'h0000, 1'b1, 11'd0, 1'b0},
      '{ROW_LOOKUP,   16'hFFFF, 1'b1, 11'd1, 1'b0},
      '{ROW_LOOKUP,   16'h5555, 1'b1, 11'd2, 1'b1},
      '{ROW_LOOKUP,   16'hAAAA, 1'b1, 11'd3, 1'b1},
      '{ROW_LOOKUP,   16'hAAAA, 1'b1, 11'd3, 1'b0},
      // capacity below fill count: only the two most recent stay visible
      '{ROW_CAPACITY, 16'd2,    1'b0, 11'd0, 1'b0},
      '{ROW_LOOKUP,   16'h0000, 1'b1, 11'd2, 1'b1},
      '{ROW_LOOKUP,   16'hFFFF, 1'b0, 11'd0, 1'b0},
      '{ROW_LOOKUP,   16'h0000, 1'b0, 11'd0, 1'b0},
      // above the built size, clamps; hidden entries come back
      '{ROW_CAPACITY, 16'd4095, 1'b0, 11'd0, 1'b0},
      '{ROW_LOOKUP,   16'h0000, 1'b0, 11'd0, 1'b0},
      '{ROW_LOOKUP,   16'h1234, 1'b1, 11'd4, 1'b1},
      // zero behaves as one entry
      '{ROW_CAPACITY, 16'd0,    1'b0, 11'd0, 1'b0},
      '{ROW_LOOKUP,   16'h8001, 1'b1, 11'd4, 1'b1},
      '{ROW_LOOKUP,   16'h8001, 1'b1, 11'd4, 1'b0},
      '{ROW_LOOKUP,   16'h7FFE, 1'b0, 11'd0, 1'b0},
      '{ROW_CAPACITY, 16'd1,    1'b0, 11'd0, 1'b0},
      '{ROW_LOOKUP,   16'h7FFE, 1'b0, 11'd0, 1'b0},
      '{ROW_CAPACITY, 16'd2049, 1'b0, 11'd0, 1'b0},
      '{ROW_LOOKUP,   16'h00FF, 1'b0, 11'd0, 1'b0},
      '{ROW_LOOKUP,   16'hFF00, 1'b0, 11'd0, 1'b0},
      '{ROW_CAPACITY, 16'd2048, 1'b0, 11'd0, 1'b0},
      '{ROW_LOOKUP,   16'h0F0F, 1'b0, 11'd0, 1'b0},
      '{ROW_LOOKUP,   16'h0000, 1'b0, 11'd0, 1'b0},
      '{ROW_LOOKUP,   16'hFFFF, 1'b0, 11'd0, 1'b0}
    };
    phase_caps[4] = $urandom_range(2, 40);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < NUM_ROWS; r++) begin
      if (rows[r].kind == ROW_CAPACITY) begin
        write_capacity(CAP_W'(rows[r].value));
      end else begin
        pace_sender();
        lookup_code(rows[r].value, rows[r].known, rows[r].slot, rows[r].need_fill);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_capacity(CAP_W'(phase_caps[p]));
      calm_send = (p == 2);
      calm_recv = (p == 2 || p == 5);
      pool_n = $urandom_range(2, 20);
      for (int i = 0; i < pool_n; i++)
        code_pool[i] = CODE_W'($urandom);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        pace_sender();
        lookup_code(pick_code(), 1'b0, '0, 1'b0);
      end
    end

    wait_idle();
    if (bad_words == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
